// ===== rtl/apl_pkg.sv =====
// Shared types and constants for the averaged peak-hold level meter.
// No dependencies; every other file refers to this package by scoped names.
package apl_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 12;
  localparam int THR_W      = 12;
  localparam int SLOPE_W    = 10;
  localparam int OFFSET_W   = 20;
  localparam int WIN_W      = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam int AVG_COUNT_DEF = 10;

  localparam logic [THR_W-1:0]    THR_RST    = 12'd325;
  localparam logic [SLOPE_W-1:0]  SLOPE_RST  = 10'd432;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 20'd140150;
  localparam logic [WIN_W-1:0]    WIN_RST    = 8'd21;

  // calibration: peak*slope, minus offset, rounded divide by 1000
  localparam int PROD_W      = SAMPLE_W + SLOPE_W;
  localparam int CAL_X_W     = PROD_W;
  localparam int CAL_DIV     = 1000;
  localparam int CAL_HALF    = CAL_DIV / 2;
  localparam int CAL_RECIP   = (2 ** CAL_X_W) / CAL_DIV;
  localparam int CAL_RECIP_W = 13;
  localparam int CAL_Q_W     = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_THRESHOLD = 2'd0,
    CFG_SLOPE          = 2'd1,
    CFG_OFFSET         = 2'd2,
    CFG_REPORT_WINDOW  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]    zero_threshold;
    logic [SLOPE_W-1:0]  slope;
    logic [OFFSET_W-1:0] offset;
  } cal_cfg_t;

endpackage

// ===== rtl/apl_if.sv =====
// Valid/ready channel interfaces for the level meter's sample and result streams.
// Depends on apl_pkg for field widths.
interface apl_in_if;
  logic                         valid;
  logic                         ready;
  logic [apl_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface apl_out_if;
  logic                         valid;
  logic                         ready;
  logic [apl_pkg::LEVEL_W-1:0]  level_tenths;
  logic [apl_pkg::SAMPLE_W-1:0] peak_average;
  modport source (output valid, output level_tenths, output peak_average, input ready);
  modport sink (input valid, input level_tenths, input peak_average, output ready);
endinterface

// ===== rtl/apl_batch.sv =====
// Batch accumulator and constant divider: drops the first sample of each batch,
// sums the rest and emits floor(sum / AVG_COUNT). Depends on apl_pkg.
module apl_batch #(
  parameter int AVG_COUNT = apl_pkg::AVG_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [apl_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [apl_pkg::SAMPLE_W-1:0] out_avg
);

  localparam int POS_W   = $clog2(AVG_COUNT + 1);
  localparam int SUM_W   = $clog2(AVG_COUNT * ((2 ** apl_pkg::SAMPLE_W) - 1) + 1);
  localparam int RECIP_W = SUM_W + 1;
  localparam int RECIP   = (2 ** SUM_W) / AVG_COUNT;
  localparam int MUL_W   = SUM_W + RECIP_W;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt, sum_acc;
  logic               accept, batch_end;

  logic               v1_r, v2_r, v3_r;
  logic               rdy1, rdy2, rdy3;
  logic [SUM_W-1:0]   s1_sum_r, s2_sum_r;
  logic [MUL_W-1:0]   s2_prod_r;
  logic [RECIP_W-1:0] q0;
  logic [RECIP_W-1:0] rem;
  logic [RECIP_W-1:0] q_fix;
  logic [apl_pkg::SAMPLE_W-1:0] avg_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid && in_ready;

  assign batch_end = (pos_r == POS_W'(AVG_COUNT));
  assign sum_acc   = (pos_r != '0) ? sum_r + SUM_W'(in_sample) : sum_r;

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (accept) begin
      if (batch_end) begin
        pos_nxt = '0;
        sum_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        sum_nxt = sum_acc;
      end
    end
  end

  // reciprocal estimate is low by at most one; one compare fixes it
  assign q0    = s2_prod_r[MUL_W-1:SUM_W];
  assign rem   = {1'b0, s2_sum_r} - RECIP_W'(q0 * AVG_COUNT);
  assign q_fix = (rem >= RECIP_W'(AVG_COUNT)) ? q0 + RECIP_W'(1) : q0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      if (rdy1) v1_r <= accept && batch_end;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_sum_r <= sum_acc;
    if (rdy2) begin
      s2_sum_r  <= s1_sum_r;
      s2_prod_r <= MUL_W'(s1_sum_r) * MUL_W'(RECIP);
    end
    if (rdy3) avg_r <= q_fix[apl_pkg::SAMPLE_W-1:0];
  end

  assign out_valid = v3_r;
  assign out_avg   = avg_r;

endmodule

// ===== rtl/apl_peak.sv =====
// Peak hold and report window: keeps the largest average and releases it once
// per window of report_window averages. Depends on apl_pkg.
module apl_peak (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [apl_pkg::WIN_W-1:0]    report_window,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [apl_pkg::SAMPLE_W-1:0] in_avg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [apl_pkg::SAMPLE_W-1:0] out_peak
);

  logic [apl_pkg::SAMPLE_W-1:0] peak_r, peak_nxt, peak_upd;
  logic [apl_pkg::WIN_W-1:0]    win_r, win_nxt, win_inc;
  logic                         take, report;

  assign in_ready = out_ready;
  assign take     = in_valid && in_ready;

  assign peak_upd = (in_avg > peak_r) ? in_avg : peak_r;
  assign win_inc  = win_r + apl_pkg::WIN_W'(1);
  assign report   = (win_inc >= report_window);

  always_comb begin
    peak_nxt = peak_r;
    win_nxt  = win_r;
    if (take) begin
      if (report) begin
        peak_nxt = '0;
        win_nxt  = '0;
      end else begin
        peak_nxt = peak_upd;
        win_nxt  = win_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      win_r  <= '0;
    end else begin
      peak_r <= peak_nxt;
      win_r  <= win_nxt;
    end
  end

  assign out_valid = in_valid && report;
  assign out_peak  = peak_upd;

endmodule

// ===== rtl/apl_calib.sv =====
// Calibration pipeline: level = round((peak*slope - offset)/1000), zero below
// threshold, saturated; ends in the result register. Depends on apl_pkg.
module apl_calib (
  input  logic                         clk,
  input  logic                         rst_n,
  input  apl_pkg::cal_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [apl_pkg::SAMPLE_W-1:0] in_peak,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [apl_pkg::LEVEL_W-1:0]  out_level,
  output logic [apl_pkg::SAMPLE_W-1:0] out_peak
);

  localparam int XW  = apl_pkg::CAL_X_W;
  localparam int QW  = apl_pkg::CAL_Q_W;
  localparam int MW  = XW + apl_pkg::CAL_RECIP_W;
  localparam int LW  = apl_pkg::LEVEL_W;

  logic v4_r, v5_r, v6_r, v7_r;
  logic rdy4, rdy5, rdy6, rdy7;

  logic [apl_pkg::PROD_W-1:0]   s4_prod_r;
  logic                         s4_below_r;
  logic [apl_pkg::SAMPLE_W-1:0] s4_peak_r, s5_peak_r, s6_peak_r, s7_peak_r;
  logic [XW-1:0]                s5_x_r, s6_x_r;
  logic                         s5_zero_r, s6_zero_r;
  logic [MW-1:0]                s6_mul_r;
  logic [LW-1:0]                level_r;

  logic [XW-1:0] x_nxt;
  logic          zero_nxt;
  logic [QW-1:0] q0, q_fix;
  logic [XW:0]   rem;
  logic [LW-1:0] level_nxt;

  assign rdy7     = !v7_r || out_ready;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  // negative result or below threshold both read as zero
  assign zero_nxt = s4_below_r || (s4_prod_r < apl_pkg::PROD_W'(cfg.offset));
  assign x_nxt    = s4_prod_r - XW'(cfg.offset) + XW'(apl_pkg::CAL_HALF);

  assign q0    = s6_mul_r[MW-1:XW];
  assign rem   = {1'b0, s6_x_r} - (XW+1)'(q0 * apl_pkg::CAL_DIV);
  assign q_fix = (rem >= (XW+1)'(apl_pkg::CAL_DIV)) ? q0 + QW'(1) : q0;

  always_comb begin
    if (s6_zero_r) begin
      level_nxt = '0;
    end else if (q_fix > QW'((2 ** LW) - 1)) begin
      level_nxt = '1;
    end else begin
      level_nxt = q_fix[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_prod_r  <= apl_pkg::PROD_W'(in_peak) * apl_pkg::PROD_W'(cfg.slope);
      s4_below_r <= (in_peak < cfg.zero_threshold);
      s4_peak_r  <= in_peak;
    end
    if (rdy5) begin
      s5_x_r    <= x_nxt;
      s5_zero_r <= zero_nxt;
      s5_peak_r <= s4_peak_r;
    end
    if (rdy6) begin
      s6_mul_r  <= MW'(s5_x_r) * MW'(apl_pkg::CAL_RECIP);
      s6_x_r    <= s5_x_r;
      s6_zero_r <= s5_zero_r;
      s6_peak_r <= s5_peak_r;
    end
    if (rdy7) begin
      level_r   <= level_nxt;
      s7_peak_r <= s6_peak_r;
    end
  end

  assign out_valid = v7_r;
  assign out_level = level_r;
  assign out_peak  = s7_peak_r;

endmodule

// ===== rtl/averaged_peak_hold_level_meter_core.sv =====
// Averaged peak-hold level meter. Takes one 12-bit converter sample per clock
// (in_ch); in_ready stays high unless the result register is held by a stalled
// consumer and the internal stages behind it have filled. Samples come in
// batches of AVG_COUNT+1: the first of each batch is dropped, the remaining
// AVG_COUNT are summed and divided (floor) into a batch average. The largest
// average of each window of report_window averages is held; when the window
// closes one result item leaves on out_ch: level_tenths =
// round((peak*slope - offset)/1000), forced to 0 when peak < zero_threshold or
// the difference is negative, saturated at 4095, plus the peak itself. The peak
// and window count then clear. The sample closing a window passes through
// three divider stages, then four calibration stages ending in the result
// register; the peak update is combinational between them. Configuration is
// written through cfg_we/cfg_index/cfg_wdata and should only change while the
// stream is idle; a write leaves the batch and window counters alone. Depends
// on apl_pkg, apl_if, apl_batch, apl_peak and apl_calib.
module averaged_peak_hold_level_meter_core #(
  parameter int AVG_COUNT = apl_pkg::AVG_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  apl_in_if.sink                         in_ch,
  apl_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [apl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [apl_pkg::THR_W-1:0]    thr_r;
  logic [apl_pkg::SLOPE_W-1:0]  slope_r;
  logic [apl_pkg::OFFSET_W-1:0] offset_r;
  logic [apl_pkg::WIN_W-1:0]    win_r;

  apl_pkg::cal_cfg_t cal_cfg;

  // batch average -> peak stage
  logic                         avg_valid, avg_ready;
  logic [apl_pkg::SAMPLE_W-1:0] avg;
  // peak stage -> calibration
  logic                         pk_valid, pk_ready;
  logic [apl_pkg::SAMPLE_W-1:0] pk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= apl_pkg::THR_RST;
      slope_r  <= apl_pkg::SLOPE_RST;
      offset_r <= apl_pkg::OFFSET_RST;
      win_r    <= apl_pkg::WIN_RST;
    end else if (cfg_we) begin
      case (apl_pkg::cfg_idx_t'(cfg_index))
        apl_pkg::CFG_ZERO_THRESHOLD: thr_r    <= cfg_wdata[apl_pkg::THR_W-1:0];
        apl_pkg::CFG_SLOPE:          slope_r  <= cfg_wdata[apl_pkg::SLOPE_W-1:0];
        apl_pkg::CFG_OFFSET:         offset_r <= cfg_wdata[apl_pkg::OFFSET_W-1:0];
        apl_pkg::CFG_REPORT_WINDOW:  win_r    <= cfg_wdata[apl_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cal_cfg.zero_threshold = thr_r;
  assign cal_cfg.slope          = slope_r;
  assign cal_cfg.offset         = offset_r;

  apl_batch #(
    .AVG_COUNT (AVG_COUNT)
  ) u_batch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_sample (in_ch.sample),
    .out_valid (avg_valid),
    .out_ready (avg_ready),
    .out_avg   (avg)
  );

  // a window length of zero closes on every average, same as one
  apl_peak u_peak (
    .clk           (clk),
    .rst_n         (rst_n),
    .report_window (win_r),
    .in_valid      (avg_valid),
    .in_ready      (avg_ready),
    .in_avg        (avg),
    .out_valid     (pk_valid),
    .out_ready     (pk_ready),
    .out_peak      (pk)
  );

  apl_calib u_calib (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cal_cfg),
    .in_valid  (pk_valid),
    .in_ready  (pk_ready),
    .in_peak   (pk),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_level (out_ch.level_tenths),
    .out_peak  (out_ch.peak_average)
  );

endmodule

// ===== bench/testbench.sv =====
// Testbench for averaged_peak_hold_level_meter_core: directed and random sample streams,
// checked item by item against an in-bench model of the batch average, peak hold and calibration.
// Depends on apl_pkg, apl_if and the core RTL.
module testbench;

  localparam int SAMPLE_W     = apl_pkg::SAMPLE_W;
  localparam int LEVEL_W      = apl_pkg::LEVEL_W;
  localparam int THR_W        = apl_pkg::THR_W;
  localparam int SLOPE_W      = apl_pkg::SLOPE_W;
  localparam int OFFSET_W     = apl_pkg::OFFSET_W;
  localparam int WIN_W        = apl_pkg::WIN_W;
  localparam int CFG_IDX_W    = apl_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = apl_pkg::CFG_DATA_W;

  localparam int AVG_COUNT    = apl_pkg::AVG_COUNT_DEF;
  localparam int BATCH_LEN    = AVG_COUNT + 1;
  localparam int LEVEL_MAX    = (1 << LEVEL_W) - 1;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int DRAIN_CYCLES = 24;      // margin over the core pipeline depth
  localparam int HOLD_CYCLES  = 2000;    // long receiver hold-off for the pressure phase
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [LEVEL_W-1:0]  level_tenths;
    logic [SAMPLE_W-1:0] peak_average;
  } level_report_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  apl_in_if  in_ch ();
  apl_out_if out_ch ();

  averaged_peak_hold_level_meter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Level meter model: its own copy of the registers and the running state.
  // Advanced once per accepted sample item, from the driver process.
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]    thr_reg;
  logic [SLOPE_W-1:0]  slope_reg;
  logic [OFFSET_W-1:0] offset_reg;
  logic [WIN_W-1:0]    window_reg;

  logic [5:0]          batch_pos;
  logic [17:0]         batch_total;
  logic [WIN_W-1:0]    window_pos;
  logic [SAMPLE_W-1:0] peak_level;

  level_report_t level_reports_due[$];   // reports predicted, not yet seen on out_ch

  logic [SAMPLE_W-1:0] pending_samples[$];  // items waiting for the driver
  int pushed_total;
  int accepted_total;
  int fail_count;
  int cycle_count;

  // idling controls, set per phase by the stimulus process
  bit src_idle_on;
  bit snk_idle_on;
  int hold_req;

  function automatic logic [LEVEL_W-1:0] calibrated_level(input logic [SAMPLE_W-1:0] peak);
    logic [31:0] prod;
    logic [31:0] lvl;
    if (peak < thr_reg) return '0;
    prod = 32'(peak) * 32'(slope_reg);
    // negative calibration clamps to zero
    if (prod < 32'(offset_reg)) return '0;
    // round half up, then saturate to the field
    lvl = (prod - 32'(offset_reg) + 32'd500) / 32'd1000;
    if (lvl > LEVEL_MAX) return LEVEL_W'(LEVEL_MAX);
    return lvl[LEVEL_W-1:0];
  endfunction

  task automatic meter_take_sample(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] avg;
    level_report_t rep;
    // the first sample of each batch is dropped
    if (batch_pos != 0) batch_total = batch_total + 18'(s);
    if (batch_pos < AVG_COUNT) begin
      batch_pos = batch_pos + 1'b1;
      return;
    end
    avg = SAMPLE_W'(batch_total / AVG_COUNT);   // floor
    batch_pos = '0;
    batch_total = '0;
    if (avg > peak_level) peak_level = avg;
    window_pos = window_pos + 1'b1;
    // a window of zero behaves as one: the compare below fails on every average
    if (window_pos < window_reg) return;
    rep.level_tenths = calibrated_level(peak_level);
    rep.peak_average = peak_level;
    level_reports_due.push_back(rep);
    window_pos = '0;
    peak_level = '0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, and a hard stop on a hung run.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(9, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the queued items on in_ch; each accepted item goes to the
  // model at the edge where it is taken.
  // ---------------------------------------------------------------------------
  int src_gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= '0;
      src_gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        meter_take_sample(in_ch.sample);
        accepted_total++;
      end
      // the current item may only be replaced once it has gone or was never offered
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap_left > 0) begin
          src_gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_ch.valid  <= 1'b1;
          in_ch.sample <= pending_samples.pop_front();
          if (src_idle_on && $urandom_range(0, 2) == 0) src_gap_left = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each accepted report with the oldest prediction and
  // drives out_ch.ready, including the long hold-off on request.
  // ---------------------------------------------------------------------------
  int snk_stall_left;
  int hold_left;
  int hold_seen;

  always @(posedge clk) begin
    level_report_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_stall_left = 0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (level_reports_due.size() == 0) begin
          $error("unexpected report: level_tenths %0d peak_average %0d",
                 out_ch.level_tenths, out_ch.peak_average);
          fail_count++;
        end else begin
          want = level_reports_due.pop_front();
          if (out_ch.level_tenths !== want.level_tenths) begin
            $error("level_tenths: expected %0d, got %0d", want.level_tenths,
                   out_ch.level_tenths);
            fail_count++;
          end
          if (out_ch.peak_average !== want.peak_average) begin
            $error("peak_average: expected %0d, got %0d", want.peak_average,
                   out_ch.peak_average);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (snk_stall_left > 0) begin
        snk_stall_left--;
        out_ch.ready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
        snk_stall_left = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_sample(input int s);
    pending_samples.push_back(SAMPLE_W'(s));
    pushed_total++;
  endtask

  // Register write; the model copy is updated at the same edge, masked to width.
  // Only called while nothing is in flight.
  task automatic write_register(input apl_pkg::cfg_idx_t idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      apl_pkg::CFG_ZERO_THRESHOLD: thr_reg    = data[THR_W-1:0];
      apl_pkg::CFG_SLOPE:          slope_reg  = data[SLOPE_W-1:0];
      apl_pkg::CFG_OFFSET:         offset_reg = data[OFFSET_W-1:0];
      apl_pkg::CFG_REPORT_WINDOW:  window_reg = data[WIN_W-1:0];
      default: ;
    endcase
  endtask

  // Block until every item is taken and every report seen, then let the
  // pipeline run dry, since a batch that closes no window leaves no report.
  task automatic wait_for_idle();
    while (accepted_total != pushed_total || level_reports_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random setting, biased to the extremes. Unused upper data bits carry
  // noise so the register masking is exercised.
  task automatic program_random_setting();
    logic [CFG_DATA_W-1:0] noise;
    int r;
    int v;
    noise = CFG_DATA_W'($urandom());
    r = $urandom_range(0, 9);
    v = (r < 2) ? 0 : (r < 3) ? (1 << THR_W) - 1 : $urandom_range(0, 1500);
    write_register(apl_pkg::CFG_ZERO_THRESHOLD,
                   (noise & ~CFG_DATA_W'((1 << THR_W) - 1)) | CFG_DATA_W'(v));
    r = $urandom_range(0, 9);
    v = (r < 1) ? 0 : (r < 3) ? (1 << SLOPE_W) - 1 : $urandom_range(0, (1 << SLOPE_W) - 1);
    write_register(apl_pkg::CFG_SLOPE,
                   (noise & ~CFG_DATA_W'((1 << SLOPE_W) - 1)) | CFG_DATA_W'(v));
    r = $urandom_range(0, 9);
    v = (r < 2) ? 0 : (r < 3) ? (1 << OFFSET_W) - 1 : $urandom_range(0, 400000);
    write_register(apl_pkg::CFG_OFFSET, CFG_DATA_W'(v));
    r = $urandom_range(0, 99);
    v = (r < 10) ? 0 : (r < 25) ? 1 : (r < 70) ? $urandom_range(2, 3) :
        (r < 90) ? $urandom_range(4, 8) : $urandom_range(9, 20);
    write_register(apl_pkg::CFG_REPORT_WINDOW,
                   (noise & ~CFG_DATA_W'((1 << WIN_W) - 1)) | CFG_DATA_W'(v));
  endtask

  // Mix of rail values, full-range noise and a phase-local level so that
  // batch averages land across the whole range.
  function automatic int draw_sample(input int level_base);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return SAMPLE_MAX;
    if (r < 5) return $urandom_range(0, SAMPLE_MAX);
    v = level_base + $urandom_range(0, 128) - 64;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int random_items;
    int phase;
    int n;
    int eff_window;
    int level_base;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    src_idle_on  = 1'b0;
    snk_idle_on  = 1'b0;
    hold_req     = 0;
    pushed_total = 0;
    accepted_total = 0;
    fail_count   = 0;
    cycle_count  = 0;
    random_items = 0;

    // model state after reset
    thr_reg     = apl_pkg::THR_RST;
    slope_reg   = apl_pkg::SLOPE_RST;
    offset_reg  = apl_pkg::OFFSET_RST;
    window_reg  = apl_pkg::WIN_RST;
    batch_pos   = '0;
    batch_total = '0;
    window_pos  = '0;
    peak_level  = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero report window (every average reports), full gain with no
    // offset. First batch: dropped zero then full-scale samples, level
    // saturates. Second batch: dropped full-scale then zeros, below threshold.
    write_register(apl_pkg::CFG_REPORT_WINDOW, CFG_DATA_W'(0));
    write_register(apl_pkg::CFG_ZERO_THRESHOLD, CFG_DATA_W'(1));
    write_register(apl_pkg::CFG_SLOPE, CFG_DATA_W'((1 << SLOPE_W) - 1));
    write_register(apl_pkg::CFG_OFFSET, CFG_DATA_W'(0));
    queue_sample(0);
    repeat (AVG_COUNT) queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MAX);
    repeat (AVG_COUNT) queue_sample(0);
    wait_for_idle();

    // Directed: unit slope, offset 1000. Sum 25009 floors to average 2500,
    // giving an exact half that must round up to level 2.
    write_register(apl_pkg::CFG_ZERO_THRESHOLD, CFG_DATA_W'(0));
    write_register(apl_pkg::CFG_SLOPE, CFG_DATA_W'(1));
    write_register(apl_pkg::CFG_OFFSET, CFG_DATA_W'(1000));
    write_register(apl_pkg::CFG_REPORT_WINDOW, CFG_DATA_W'(1));
    queue_sample(SAMPLE_MAX);
    repeat (AVG_COUNT - 1) queue_sample(2500);
    queue_sample(2509);
    wait_for_idle();

    // Random phases, each with its own setting and idling mix.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      program_random_setting();
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      level_base  = $urandom_range(0, SAMPLE_MAX);

      if (phase == 3) begin
        // Pressure: one report per batch, sender never idles, receiver
        // holds off long enough for the core to back up onto in_ch.
        write_register(apl_pkg::CFG_REPORT_WINDOW, CFG_DATA_W'(1));
        src_idle_on = 1'b0;
        repeat (400) queue_sample(draw_sample(level_base));
        random_items += 400;
        hold_req <= hold_req + 1;
      end else if (phase == 5) begin
        // Widest window: it never closes within the item budget, and its
        // count carries over into the next setting.
        write_register(apl_pkg::CFG_REPORT_WINDOW, CFG_DATA_W'((1 << WIN_W) - 1));
        n = ((1 << WIN_W) - 1) * BATCH_LEN + $urandom_range(0, 10);
        if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
        repeat (n) queue_sample(draw_sample(level_base));
        random_items += n;
      end else begin
        eff_window = (window_reg == 0) ? 1 : window_reg;
        n = eff_window * BATCH_LEN * $urandom_range(1, 3) + $urandom_range(0, 10);
        if (n > 300) n = 300;
        if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
        repeat (n) queue_sample(draw_sample(level_base));
        random_items += n;
      end
      wait_for_idle();
    end

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
